>>> sv/ra_pkg.sv
// ----------------------------------------------------------------------------
// ra_pkg: shared types and constants for the rank assignment block
// Holds the item and result structs, field widths and the sequencer states.
// ----------------------------------------------------------------------------
package ra_pkg;

  localparam int VALUE_W       = 32;
  localparam int RANK_W        = 6;
  localparam int MAX_ITEMS_DEF = 64;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      last_in;
  } item_t;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic              last_out;
  } result_t;

  typedef enum logic [1:0] {
    S_LOAD,
    S_PIVOT,
    S_CATCH,
    S_SWEEP
  } state_t;

endpackage

>>> sv/ra_ram.sv
// ----------------------------------------------------------------------------
// ra_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ra_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/rank_assignment.sv
// ----------------------------------------------------------------------------
// rank_assignment: rank of each set element by counting smaller elements
// Loads a set of signed values, then emits for each one, in arrival order,
// how many elements of the set are strictly smaller.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                      Transfer when
//   --------  -------------------------  -----------------------------------
//   item      start, busy, item          start high and busy low at clk edge
//   result    result_strobe, result      result_strobe high (one cycle each)
//
// Elements load while busy is low; last_in or a full store closes the set
// and raises busy. Each element is then ranked in order: store read, pivot
// capture, then a sweep of the one shared comparator over every entry
// through the single read port; its result strobes the cycle after its
// sweep. Reset clears the sequencer state, counters and strobe but not the
// store, since no unwritten store entry is ever read. The receiver cannot stall.
// ----------------------------------------------------------------------------
module rank_assignment #(
  parameter int MAX_ITEMS = ra_pkg::MAX_ITEMS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  ra_pkg::item_t   item,
  output logic            result_strobe,
  output ra_pkg::result_t result
);

  // Store address width and a counter width that can hold MAX_ITEMS itself.
  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam logic [CW-1:0] CAP = CW'(MAX_ITEMS);

  ra_pkg::state_t state, state_next;

  // fill_count is the write pointer while loading and the set size n while
  // ranking. i_idx is the element being ranked, j_idx the sweep read pointer.
  logic [CW-1:0] fill_count, fill_count_next;
  logic [CW-1:0] i_idx, i_idx_next;
  logic [CW-1:0] j_idx, j_idx_next;
  logic [CW-1:0] cnt, cnt_next;
  logic          cmp_valid, cmp_valid_next;
  logic [ra_pkg::VALUE_W-1:0] pivot, pivot_next;
  ra_pkg::result_t result_next;
  logic            result_strobe_next;

  logic                       ram_we;
  logic [AW-1:0]              ram_raddr;
  logic [ra_pkg::VALUE_W-1:0] ram_rdata;
  logic                       is_less;
  logic [CW-1:0]              fill_inc;
  logic [CW-1:0]              cnt_inc;

  assign busy   = (state != ra_pkg::S_LOAD);
  assign ram_we = start && !busy;

  ra_ram #(
    .WIDTH (ra_pkg::VALUE_W),
    .DEPTH (MAX_ITEMS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill_count[AW-1:0]),
    .wdata (item.value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The one shared compare unit: signed order of the swept entry against
  // the pivot.
  assign is_less  = $signed(ram_rdata) < $signed(pivot);
  assign fill_inc = fill_count + CW'(1);
  assign cnt_inc  = cnt + CW'(is_less);

  always_comb begin
    state_next         = state;
    fill_count_next    = fill_count;
    i_idx_next         = i_idx;
    j_idx_next         = j_idx;
    cnt_next           = cnt;
    cmp_valid_next     = 1'b0;
    pivot_next         = pivot;
    result_next        = result;
    result_strobe_next = 1'b0;
    ram_raddr          = i_idx[AW-1:0];

    unique case (state)
      ra_pkg::S_LOAD: begin
        if (start) begin
          fill_count_next = fill_inc;
          if (item.last_in || fill_inc == CAP) begin
            i_idx_next = '0;
            state_next = ra_pkg::S_PIVOT;
          end
        end
      end

      ra_pkg::S_PIVOT: begin
        // Read this element's value; it lands in the read register next cycle.
        ram_raddr = i_idx[AW-1:0];
        state_next = ra_pkg::S_CATCH;
      end

      ra_pkg::S_CATCH: begin
        pivot_next     = ram_rdata;
        cnt_next       = '0;
        ram_raddr      = '0;
        j_idx_next     = CW'(1);
        cmp_valid_next = 1'b1;
        state_next     = ra_pkg::S_SWEEP;
      end

      ra_pkg::S_SWEEP: begin
        ram_raddr = j_idx[AW-1:0];
        if (cmp_valid) begin
          cnt_next = cnt_inc;
        end
        if (j_idx != fill_count) begin
          j_idx_next     = j_idx + CW'(1);
          cmp_valid_next = 1'b1;
        end else begin
          // Every entry has been issued, so this cycle holds the last compare.
          result_next.rank     = ra_pkg::RANK_W'(cnt_inc);
          result_next.last_out = (i_idx + CW'(1) == fill_count);
          result_strobe_next   = 1'b1;
          if (i_idx + CW'(1) == fill_count) begin
            fill_count_next = '0;
            state_next      = ra_pkg::S_LOAD;
          end else begin
            i_idx_next = i_idx + CW'(1);
            state_next = ra_pkg::S_PIVOT;
          end
        end
      end

      default: begin
        state_next = ra_pkg::S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ra_pkg::S_LOAD;
      fill_count    <= '0;
      i_idx         <= '0;
      j_idx         <= '0;
      cnt           <= '0;
      cmp_valid     <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      state         <= state_next;
      fill_count    <= fill_count_next;
      i_idx         <= i_idx_next;
      j_idx         <= j_idx_next;
      cnt           <= cnt_next;
      cmp_valid     <= cmp_valid_next;
      result_strobe <= result_strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    pivot  <= pivot_next;
    result <= result_next;
  end

  // A result only follows the final compare cycle of a sweep.
  a_strobe_after_sweep: assert property (@(posedge clk) disable iff (rst)
    result_strobe |-> $past(state == ra_pkg::S_SWEEP))
    else $error("result strobe without a finished sweep");

  // The fill count never passes the store capacity.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CAP)
    else $error("fill count beyond capacity");

  // The count of smaller entries never exceeds the entries issued so far.
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    state == ra_pkg::S_SWEEP |-> cnt <= j_idx)
    else $error("rank count exceeds compared entries");

  // The last result of a set leaves the block empty and ready to load.
  a_last_empties: assert property (@(posedge clk) disable iff (rst)
    result_strobe && result.last_out |-> !busy && fill_count == '0)
    else $error("set not released after its last result");

endmodule

>>> sim/rank_assignment_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rank_assignment_checker: rank prediction and comparison for rank_assignment
// Watches the item and result channels, keeps its own copy of the set being
// loaded, ranks the set when it closes and matches every result against the
// oldest rank still owed.
// ----------------------------------------------------------------------------
module rank_assignment_checker #(
  parameter int MAX_ITEMS = ra_pkg::MAX_ITEMS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            busy,
  input  ra_pkg::item_t   item,
  input  logic            result_strobe,
  input  ra_pkg::result_t result,
  output int              fail_count,
  output int              pending_count
);

  logic signed [ra_pkg::VALUE_W-1:0] set_values [MAX_ITEMS];
  int                                set_size;
  ra_pkg::result_t                   ranks_owed [$];
  ra_pkg::result_t                   oldest_rank;
  int                                mismatches;

  initial begin
    set_size   = 0;
    mismatches = 0;
  end

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  // Rank every element of the closed set, in arrival order.
  task automatic rank_current_set();
    int              smaller;
    ra_pkg::result_t owed;
    for (int i = 0; i < set_size; i++) begin
      smaller = 0;
      for (int j = 0; j < set_size; j++) begin
        if (set_values[j] < set_values[i]) begin
          smaller++;
        end
      end
      owed.rank     = ra_pkg::RANK_W'(smaller);
      owed.last_out = (i == set_size - 1);
      ranks_owed.push_back(owed);
    end
    set_size = 0;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      set_size = 0;
      ranks_owed.delete();
    end else begin
      if ($isunknown(result_strobe)) begin
        report_mismatch("result strobe is unknown");
      end else if (result_strobe) begin
        if (ranks_owed.size() == 0) begin
          report_mismatch($sformatf("unexpected result, rank %0d last_out %0b",
                                    result.rank, result.last_out));
        end else begin
          oldest_rank = ranks_owed.pop_front();
          if (result.rank !== oldest_rank.rank) begin
            report_mismatch($sformatf("rank is %0d, expected %0d",
                                      result.rank, oldest_rank.rank));
          end
          if (result.last_out !== oldest_rank.last_out) begin
            report_mismatch($sformatf("last_out is %0b, expected %0b",
                                      result.last_out, oldest_rank.last_out));
          end
        end
      end
      if (start && !busy) begin
        if (set_size >= MAX_ITEMS) begin
          set_size = 0;
        end
        set_values[set_size] = item.value;
        set_size++;
        if (item.last_in || set_size == MAX_ITEMS) begin
          rank_current_set();
        end
      end
    end
    fail_count    <= mismatches;
    pending_count <= ranks_owed.size();
  end

endmodule

>>> sim/rank_assignment_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rank_assignment_tb: top level of the rank_assignment testbench
// Loads sets of signed values into the block, first a few hand-picked sets
// around the extremes and ties, then random sets of random size with random
// idle gaps. A separate checker predicts and compares every rank.
// ----------------------------------------------------------------------------
module rank_assignment_tb;

  // The store is built at its full default depth, so capacity closes a set
  // at 64 elements.
  localparam int SET_CAP     = ra_pkg::MAX_ITEMS_DEF;
  localparam int ITEM_TARGET = 480;

  // How the values of one set are spread. Narrow sets produce many ties,
  // edge sets sit at and next to the most negative and most positive values.
  typedef enum int {
    SPREAD_WIDE,
    SPREAD_NARROW,
    SPREAD_EDGE
  } spread_t;

  logic            clk;
  logic            rst;
  logic            start;
  logic            busy;
  ra_pkg::item_t   item;
  logic            result_strobe;
  ra_pkg::result_t result;
  int              fail_count;
  int              pending_count;
  int              items_sent;

  rank_assignment #(
    .MAX_ITEMS(SET_CAP)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result_strobe(result_strobe),
    .result       (result)
  );

  rank_assignment_checker #(
    .MAX_ITEMS(SET_CAP)
  ) checker_inst (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .result_strobe(result_strobe),
    .result       (result),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs, for example if busy never drops. The
  // slowest correct run, with full sets and the longest gaps throughout, is
  // under a fifth of this.
  initial begin
    #1_000_000;
    $display("FAIL rank_assignment");
    $finish;
  end

  // Idle length between transfers: mostly none or a few cycles, now and then
  // a long pause, so gaps land on loading as well as on every ranking phase.
  function automatic int idle_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      return 0;
    end else if (pick < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [31:0] draw_value(input spread_t spread);
    case (spread)
      SPREAD_NARROW: begin
        return 32'(int'($urandom_range(0, 8)) - 4);
      end
      SPREAD_EDGE: begin
        case ($urandom_range(0, 5))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          2:       return 32'h0000_0000;
          3:       return 32'hFFFF_FFFF;
          4:       return 32'h8000_0000 + $urandom_range(0, 3);
          default: return 32'h7FFF_FFFF - $urandom_range(0, 3);
        endcase
      end
      default: begin
        return $urandom;
      end
    endcase
  endfunction

  // One item transfer: hold start and the item until the block takes it at
  // an edge where busy is low, then idle for a random while unless the caller
  // wants back-to-back transfers. While idle, the item bus carries junk that
  // the block must ignore.
  task automatic send_item(input logic signed [31:0] value, input logic last_in,
                           input bit back_to_back);
    ra_pkg::item_t next_item;
    int            gap;
    next_item.value   = value;
    next_item.last_in = last_in;
    start <= 1'b1;
    item  <= next_item;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
    items_sent++;
    gap = back_to_back ? 0 : idle_length();
    if (gap > 0) begin
      next_item.value   = $urandom;
      next_item.last_in = 1'($urandom_range(0, 1));
      start <= 1'b0;
      item  <= next_item;
      repeat (gap) @(posedge clk);
    end
  endtask

  // A whole set. The closing flag only matters on the final element; a set
  // shorter than the capacity must close with last_in set.
  task automatic send_set(input int size, input bit close_flag, input spread_t spread,
                          input bit back_to_back);
    for (int k = 0; k < size; k++) begin
      send_item(draw_value(spread), (k == size - 1) ? close_flag : 1'b0, back_to_back);
    end
  endtask

  initial begin
    int      pick;
    int      size;
    spread_t spread;
    rst        = 1'b1;
    start      = 1'b0;
    item       = '0;
    items_sent = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed sets. A single element at either extreme must rank 0 and
    // close the set on its own.
    send_item(32'h8000_0000, 1'b1, 1'b0);
    send_item(32'h7FFF_FFFF, 1'b1, 1'b0);
    // Both extremes, zero, minus one, one and a repeated zero: checks the
    // signed order across the sign boundary and that ties share a rank.
    send_item(32'h7FFF_FFFF, 1'b0, 1'b0);
    send_item(32'h8000_0000, 1'b0, 1'b0);
    send_item(32'h0000_0000, 1'b0, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b0, 1'b0);
    send_item(32'h0000_0001, 1'b0, 1'b0);
    send_item(32'h0000_0000, 1'b1, 1'b0);
    // All elements equal: every rank is 0.
    send_item(32'd5, 1'b0, 1'b1);
    send_item(32'd5, 1'b0, 1'b1);
    send_item(32'd5, 1'b1, 1'b1);
    // Strictly descending: ranks come out in reverse order.
    send_item(32'd3, 1'b0, 1'b0);
    send_item(32'd2, 1'b0, 1'b0);
    send_item(32'd1, 1'b0, 1'b0);
    send_item(32'd0, 1'b1, 1'b0);

    // Full sets: one closed by capacity alone, one where the final element
    // also carries last_in.
    send_set(SET_CAP, 1'b0, SPREAD_WIDE, 1'b0);
    send_set(SET_CAP, 1'b1, SPREAD_NARROW, 1'b1);

    // Random sets. Most are small so that ranking stays cheap; a few run to
    // the capacity, where last_in on the final element is random.
    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        size = SET_CAP;
      end else if (pick == 1) begin
        size = $urandom_range(13, SET_CAP - 1);
      end else begin
        size = $urandom_range(1, 12);
      end
      spread = spread_t'($urandom_range(0, 2));
      send_set(size, (size == SET_CAP) ? 1'($urandom_range(0, 1)) : 1'b1, spread,
               $urandom_range(0, 3) == 0);
    end

    // Drain: the checker's pending count is registered, so step the clock
    // before looking at it, then keep watching for any stray result.
    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) begin
      @(posedge clk);
    end
    repeat (16) @(posedge clk);

    if (fail_count == 0 && pending_count == 0) begin
      $display("PASS rank_assignment");
    end else begin
      $display("FAIL rank_assignment");
    end
    $finish;
  end

endmodule
